### hdl/gregorian_day_difference_assert.svh
// Assertion macros for the day-difference RTL.
// Expects i_clk and i_rst_n in the scope of use.
`ifndef GREGORIAN_DAY_DIFFERENCE_ASSERT_SVH
`define GREGORIAN_DAY_DIFFERENCE_ASSERT_SVH

// same-cycle implication, checked out of reset
`define GDD_ASSERT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("gdd assertion failed");

// next-cycle implication, checked out of reset
`define GDD_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("gdd assertion failed");

`endif

### hdl/gdd_pkg.sv
// Shared types, constants and calendar tables for the day-difference block.
// No dependencies.
`default_nettype none

package gdd_pkg;

    localparam int unsigned DAY_W  = 6;
    localparam int unsigned MON_W  = 4;
    localparam int unsigned YEAR_W = 14;
    localparam int unsigned YY_W   = 15;   // year + 400, fits 15 bits
    localparam int unsigned Q_W    = 9;    // quotient by 100 of YY_W values
    localparam int unsigned DN_W   = 23;   // day number
    localparam int unsigned CNT_W  = 22;   // day count output
    localparam int unsigned PROD_W = 30;   // reciprocal product

    // x / 100 == (x * DIV100_MUL) >> DIV100_SHIFT for x < 43690
    localparam logic [PROD_W-1:0] DIV100_MUL   = PROD_W'(20972);
    localparam int unsigned       DIV100_SHIFT = 21;

    localparam logic [YEAR_W-1:0] EARLIEST_RESET = YEAR_W'(1582);

    typedef logic [1:0] t_status;
    localparam t_status STATUS_OK = 2'd0;
    localparam t_status BAD_MONTH = 2'd1;
    localparam t_status BAD_DAY   = 2'd2;
    localparam t_status BAD_YEAR  = 2'd3;

    localparam logic [MON_W-1:0] MON_JAN = MON_W'(1);
    localparam logic [MON_W-1:0] MON_FEB = MON_W'(2);
    localparam logic [MON_W-1:0] MON_DEC = MON_W'(12);

    // per-date result out of the date unit
    typedef struct packed {
        t_status         fault;
        logic [DN_W-1:0] dn_hi;
        logic [DN_W-1:0] dn_lo;
    } t_date_res;

    function automatic logic [4:0] month_len(input logic [MON_W-1:0] m, input logic leap);
        logic [4:0] len;
        len = 5'd31;
        unique case (m)
            4'd2:                      len = leap ? 5'd29 : 5'd28;
            4'd4, 4'd6, 4'd9, 4'd11:   len = 5'd30;
            default:                   len = 5'd31;
        endcase
        return len;
    endfunction

    // days before the month in a March-based year
    function automatic logic [8:0] month_offset(input logic [MON_W-1:0] m);
        logic [8:0] off;
        off = 9'd0;
        unique case (m)
            4'd1:    off = 9'd306;
            4'd2:    off = 9'd337;
            4'd3:    off = 9'd0;
            4'd4:    off = 9'd31;
            4'd5:    off = 9'd61;
            4'd6:    off = 9'd92;
            4'd7:    off = 9'd122;
            4'd8:    off = 9'd153;
            4'd9:    off = 9'd184;
            4'd10:   off = 9'd214;
            4'd11:   off = 9'd245;
            4'd12:   off = 9'd275;
            default: off = 9'd0;
        endcase
        return off;
    endfunction

endpackage

`default_nettype wire

### hdl/gdd_date_unit.sv
// Two-stage date checker and day-number front end for one date.
// Depends on gdd_pkg.
`default_nettype none

module gdd_date_unit #(
    parameter int unsigned MAX_YEAR = 9999
) (
    input  wire logic                        i_clk,
    input  wire logic [gdd_pkg::DAY_W-1:0]   i_day,
    input  wire logic [gdd_pkg::MON_W-1:0]   i_month,
    input  wire logic [gdd_pkg::YEAR_W-1:0]  i_year,
    input  wire logic [gdd_pkg::YEAR_W-1:0]  i_earliest,
    output gdd_pkg::t_date_res               o_res
);
    import gdd_pkg::*;

    localparam logic [16:0] MaxYearW = 17'(MAX_YEAR);

    // stage 1
    logic [DAY_W-1:0]  r_d;
    logic [MON_W-1:0]  r_m;
    logic [YEAR_W-1:0] r_y;
    logic [YY_W-1:0]   r_yy;
    logic [Q_W-1:0]    r_qy;
    logic [Q_W-1:0]    r_qq;
    logic [8:0]        r_moff;

    logic [YY_W-1:0]   n_yy;
    logic [PROD_W-1:0] prod_y;
    logic [PROD_W-1:0] prod_yy;

    always_comb begin
        n_yy    = YY_W'(i_year) + YY_W'(400) - ((i_month <= MON_FEB) ? YY_W'(1) : YY_W'(0));
        prod_y  = PROD_W'(i_year) * DIV100_MUL;
        prod_yy = PROD_W'(n_yy) * DIV100_MUL;
    end

    always_ff @(posedge i_clk) begin
        r_d    <= i_day;
        r_m    <= i_month;
        r_y    <= i_year;
        r_yy   <= n_yy;
        r_qy   <= prod_y[DIV100_SHIFT +: Q_W];
        r_qq   <= prod_yy[DIV100_SHIFT +: Q_W];
        r_moff <= month_offset(i_month);
    end

    // stage 2: validity and day-number partial sums
    logic [YEAR_W-1:0] hund;
    logic              leap;
    t_status           n_fault;
    logic [DN_W-1:0]   n_hi;
    logic [DN_W-1:0]   n_lo;

    always_comb begin
        hund = YEAR_W'(r_qy) * YEAR_W'(100);
        leap = (r_y[1:0] == 2'b00) && ((r_y != hund) || (r_qy[1:0] == 2'b00));
        priority if (r_m < MON_JAN || r_m > MON_DEC) begin
            n_fault = BAD_MONTH;
        end else if (r_d == '0 || 5'(r_d) > month_len(r_m, leap) || r_d[DAY_W-1]) begin
            n_fault = BAD_DAY;
        end else if (r_y < i_earliest || 17'(r_y) > MaxYearW) begin
            n_fault = BAD_YEAR;
        end else begin
            n_fault = STATUS_OK;
        end
        // yy/4 >= yy/100, so the high part never goes negative
        n_hi = DN_W'(r_yy) * DN_W'(365) + DN_W'(r_yy[YY_W-1:2]) - DN_W'(r_qq);
        n_lo = DN_W'(r_qq[Q_W-1:2]) + DN_W'(r_moff) + DN_W'(r_d) - DN_W'(1);
    end

    always_ff @(posedge i_clk) begin
        o_res.fault <= n_fault;
        o_res.dn_hi <= n_hi;
        o_res.dn_lo <= n_lo;
    end

endmodule

`default_nettype wire

### hdl/gregorian_day_difference.sv
// Top level: days between two Gregorian dates, four-stage pipeline.
// Depends on gdd_pkg, gdd_date_unit and gregorian_day_difference_assert.svh.
//
// Usage:
//   A transaction is taken at a rising edge with start high and busy low;
//   busy stays low, so a date pair may be presented every cycle.
//   Each date is given as day, month and year on its own ports.
//   The result (status, bad_date, day_count) is registered in the output
//   register of stage four and is marked by o_strobe for exactly one cycle.
//   Throughput is one transaction per cycle; four register stages:
//   reciprocal divide, date check and partial sums, day-number add, then
//   absolute difference with saturation into the output register.
//   The receiver cannot stall: every result is taken in its strobe cycle.
//   Status 0 ok, 1 bad month, 2 bad day, 3 bad year; the first date is
//   checked before the second, month before day before year.
//   earliest_year is written through i_cfg_we / i_cfg_wdata; the user must
//   write it only while no transaction is in flight; the block has no check.
//   Reset, synchronous and active low, sets it to 1582 and empties the pipe.
`default_nettype none

module gregorian_day_difference #(
    parameter int unsigned MAX_YEAR = 9999
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        start,
    output logic                             busy,
    input  wire logic [gdd_pkg::DAY_W-1:0]   i_first_day,
    input  wire logic [gdd_pkg::MON_W-1:0]   i_first_month,
    input  wire logic [gdd_pkg::YEAR_W-1:0]  i_first_year,
    input  wire logic [gdd_pkg::DAY_W-1:0]   i_second_day,
    input  wire logic [gdd_pkg::MON_W-1:0]   i_second_month,
    input  wire logic [gdd_pkg::YEAR_W-1:0]  i_second_year,
    input  wire logic                        i_cfg_we,
    input  wire logic [gdd_pkg::YEAR_W-1:0]  i_cfg_wdata,
    output logic                             o_strobe,
    output logic [1:0]                       o_status,
    output logic                             o_bad_date,
    output logic [gdd_pkg::CNT_W-1:0]        o_day_count
);
    import gdd_pkg::*;

    `include "gregorian_day_difference_assert.svh"

    assign busy = 1'b0;

    logic [YEAR_W-1:0] r_earliest;
    logic [2:0]        r_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_earliest <= EARLIEST_RESET;
            r_vld      <= '0;
            o_strobe   <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_earliest <= i_cfg_wdata;
            end
            r_vld    <= {r_vld[1:0], start && !busy};
            o_strobe <= r_vld[2];
        end
    end

    t_date_res res1;
    t_date_res res2;

    gdd_date_unit #(.MAX_YEAR(MAX_YEAR)) u_first (
        .i_clk      (i_clk),
        .i_day      (i_first_day),
        .i_month    (i_first_month),
        .i_year     (i_first_year),
        .i_earliest (r_earliest),
        .o_res      (res1)
    );

    gdd_date_unit #(.MAX_YEAR(MAX_YEAR)) u_second (
        .i_clk      (i_clk),
        .i_day      (i_second_day),
        .i_month    (i_second_month),
        .i_year     (i_second_year),
        .i_earliest (r_earliest),
        .o_res      (res2)
    );

    // stage 3: fault priority and full day numbers
    t_status         r_fault;
    logic            r_bad;
    logic [DN_W-1:0] r_dn1;
    logic [DN_W-1:0] r_dn2;

    always_ff @(posedge i_clk) begin
        if (res1.fault != STATUS_OK) begin
            r_fault <= res1.fault;
            r_bad   <= 1'b0;
        end else begin
            r_fault <= res2.fault;
            r_bad   <= (res2.fault != STATUS_OK);
        end
        r_dn1 <= res1.dn_hi + res1.dn_lo;
        r_dn2 <= res2.dn_hi + res2.dn_lo;
    end

    // stage 4: absolute difference, saturate, output
    logic [DN_W-1:0] diff;

    always_comb begin
        diff = (r_dn1 >= r_dn2) ? (r_dn1 - r_dn2) : (r_dn2 - r_dn1);
    end

    always_ff @(posedge i_clk) begin
        o_status   <= r_fault;
        o_bad_date <= r_bad;
        if (r_fault != STATUS_OK) begin
            o_day_count <= '0;
        end else if (diff[DN_W-1:CNT_W] != '0) begin
            o_day_count <= '1;
        end else begin
            o_day_count <= diff[CNT_W-1:0];
        end
    end

    `GDD_ASSERT(a_strobe_src, o_strobe, $past(start, 4))
    `GDD_ASSERT(a_fail_zero, o_strobe && o_status != STATUS_OK, o_day_count == '0)
    `GDD_ASSERT(a_ok_first, o_strobe && o_status == STATUS_OK, !o_bad_date)
    `GDD_ASSERT_NEXT(a_pipe_step, r_vld[2], o_strobe)

endmodule

`default_nettype wire

### sim/testbench.sv
// Self-checking bench for gregorian_day_difference: date pairs in, status and day gap out.
// Depends on gdd_pkg and the gregorian_day_difference RTL; predicts each result
// in the bench and checks it against the DUT in order.
`default_nettype none

module testbench;
    import gdd_pkg::*;

    localparam int unsigned YEAR_CEILING = 9999;
    localparam int unsigned CYCLE_LIMIT  = 100000;
    localparam int unsigned SETTLE_CYCLES = 8;     // pipe is 4 deep
    localparam longint unsigned COUNT_SAT = (64'd1 << CNT_W) - 1;
    localparam logic FIRST_DATE  = 1'b0;
    localparam logic SECOND_DATE = 1'b1;

    typedef struct packed {
        logic [DAY_W-1:0]  d;
        logic [MON_W-1:0]  m;
        logic [YEAR_W-1:0] y;
    } t_cal_date;

    typedef struct packed {
        t_status           status;
        logic              bad_date;
        logic [CNT_W-1:0]  day_count;
    } t_day_gap;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               start = 1'b0;
    logic               busy;
    logic [DAY_W-1:0]   i_first_day = '0;
    logic [MON_W-1:0]   i_first_month = '0;
    logic [YEAR_W-1:0]  i_first_year = '0;
    logic [DAY_W-1:0]   i_second_day = '0;
    logic [MON_W-1:0]   i_second_month = '0;
    logic [YEAR_W-1:0]  i_second_year = '0;
    logic               i_cfg_we = 1'b0;
    logic [YEAR_W-1:0]  i_cfg_wdata = '0;
    logic               o_strobe;
    logic [1:0]         o_status;
    logic               o_bad_date;
    logic [CNT_W-1:0]   o_day_count;

    logic [YEAR_W-1:0]  earliest_year = EARLIEST_RESET;
    t_day_gap           pending_gaps[$];
    int unsigned        error_count = 0;
    int unsigned        cycle_count = 0;

    gregorian_day_difference #(
        .MAX_YEAR(YEAR_CEILING)
    ) dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_first_day    (i_first_day),
        .i_first_month  (i_first_month),
        .i_first_year   (i_first_year),
        .i_second_day   (i_second_day),
        .i_second_month (i_second_month),
        .i_second_year  (i_second_year),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata),
        .o_strobe       (o_strobe),
        .o_status       (o_status),
        .o_bad_date     (o_bad_date),
        .o_day_count    (o_day_count)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // ---------------- calendar predictor ----------------

    function automatic int unsigned days_in_month(input logic [MON_W-1:0] m,
                                                  input logic [YEAR_W-1:0] y);
        bit leap;
        leap = (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
        if (m == MON_FEB)
            return leap ? 29 : 28;
        if (m == 4 || m == 6 || m == 9 || m == 11)
            return 30;
        return 31;
    endfunction

    function automatic t_status date_fault(input t_cal_date c);
        if (c.m < MON_JAN || c.m > MON_DEC)
            return BAD_MONTH;
        if (c.d < 1 || c.d > days_in_month(c.m, c.y))
            return BAD_DAY;
        if (c.y < earliest_year || c.y > YEAR_CEILING)
            return BAD_YEAR;
        return STATUS_OK;
    endfunction

    // days from a fixed origin, year starting in March
    function automatic longint unsigned day_index(input t_cal_date c);
        longint unsigned yy;
        longint unsigned mp;
        yy = 64'(c.y) + 400 - ((c.m <= MON_FEB) ? 1 : 0);
        mp = (64'(c.m) + 9) % 12;
        return 365 * yy + yy / 4 - yy / 100 + yy / 400 + (153 * mp + 2) / 5 + 64'(c.d) - 1;
    endfunction

    function automatic t_day_gap predict_gap(input t_cal_date a, input t_cal_date b);
        t_day_gap        r;
        t_status         f;
        longint unsigned ia;
        longint unsigned ib;
        longint unsigned diff;
        r = '0;
        f = date_fault(a);
        if (f != STATUS_OK) begin
            r.status = f;
            r.bad_date = FIRST_DATE;
            return r;
        end
        f = date_fault(b);
        if (f != STATUS_OK) begin
            r.status = f;
            r.bad_date = SECOND_DATE;
            return r;
        end
        ia = day_index(a);
        ib = day_index(b);
        diff = (ia > ib) ? ia - ib : ib - ia;
        if (diff > COUNT_SAT)
            diff = COUNT_SAT;
        r.status = STATUS_OK;
        r.day_count = diff[CNT_W-1:0];
        return r;
    endfunction

    function automatic t_cal_date on_day(input int unsigned d, input int unsigned m,
                                         input int unsigned y);
        t_cal_date c;
        c.d = DAY_W'(d);
        c.m = MON_W'(m);
        c.y = YEAR_W'(y);
        return c;
    endfunction

    // random date with edge cases, or with one field redrawn or pushed out of range
    function automatic t_cal_date gen_date(input bit well_formed);
        t_cal_date   c;
        int unsigned lo;
        lo = (earliest_year > YEAR_CEILING) ? 0 : earliest_year;
        c.y = YEAR_W'($urandom_range(YEAR_CEILING, lo));
        c.m = MON_W'($urandom_range(12, 1));
        c.d = DAY_W'($urandom_range(days_in_month(c.m, c.y), 1));
        if (well_formed) begin
            case ($urandom_range(0, 7))
                0: begin
                    c.m = MON_FEB;
                    c.d = DAY_W'(29);
                end
                1: c.y = YEAR_W'(lo);
                2: c.y = YEAR_W'(YEAR_CEILING);
                3: c.d = DAY_W'(days_in_month(c.m, c.y));
                default: ;
            endcase
        end else begin
            case ($urandom_range(0, 4))
                0: c.d = DAY_W'($urandom_range(63, 0));
                1: c.m = MON_W'($urandom_range(15, 0));
                2: c.y = YEAR_W'($urandom_range(16383, 0));
                3: c.y = (lo > 0) ? YEAR_W'(lo - 1) : YEAR_W'(YEAR_CEILING + 1);
                default: c.d = DAY_W'(days_in_month(c.m, c.y) + 1);
            endcase
        end
        return c;
    endfunction

    // ---------------- drivers ----------------

    task automatic send_dates(input t_cal_date a, input t_cal_date b);
        start          <= 1'b1;
        i_first_day    <= a.d;
        i_first_month  <= a.m;
        i_first_year   <= a.y;
        i_second_day   <= b.d;
        i_second_month <= b.m;
        i_second_year  <= b.y;
        do @(posedge i_clk); while (busy !== 1'b0);
        pending_gaps.push_back(predict_gap(a, b));
    endtask

    task automatic maybe_pause(input bit allow);
        if (allow && $urandom_range(0, 3) == 0) begin
            start <= 1'b0;
            repeat ($urandom_range(5, 1)) @(posedge i_clk);
        end
    endtask

    // drop start and let the pipe empty
    task automatic settle();
        start <= 1'b0;
        while (pending_gaps.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_earliest(input logic [YEAR_W-1:0] value);
        settle();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        earliest_year = value;
    endtask

    // ---------------- checking ----------------

    task automatic report_mismatch(input string what);
        error_count++;
        // keep the log short on a broken build
        if (error_count <= 40)
            $display("ERROR @%0t: %s", $time, what);
    endtask

    always @(posedge i_clk) begin
        t_day_gap want;
        if (i_rst_n && o_strobe) begin
            if (pending_gaps.size() == 0) begin
                report_mismatch("result strobe with no transaction pending");
            end else begin
                want = pending_gaps.pop_front();
                if (o_status !== want.status)
                    report_mismatch($sformatf("status %0d, want %0d", o_status, want.status));
                if (o_bad_date !== want.bad_date)
                    report_mismatch($sformatf("bad_date %0d, want %0d",
                                              o_bad_date, want.bad_date));
                if (o_day_count !== want.day_count)
                    report_mismatch($sformatf("day_count %0d, want %0d",
                                              o_day_count, want.day_count));
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("== FAIL ==");
            $finish;
        end
    end

    // ---------------- tests ----------------

    // runs with the reset floor of 1582
    task automatic test_calendar_rules();
        send_dates(on_day(1, 1, 1582),   on_day(1, 1, 1582));
        send_dates(on_day(1, 1, 1582),   on_day(31, 12, 9999));
        send_dates(on_day(31, 12, 9999), on_day(1, 1, 1582));
        send_dates(on_day(29, 2, 2000),  on_day(1, 3, 2000));
        send_dates(on_day(29, 2, 1900),  on_day(1, 1, 2000));
        send_dates(on_day(29, 2, 2004),  on_day(28, 2, 2001));
        send_dates(on_day(1, 1, 2000),   on_day(29, 2, 2001));
        send_dates(on_day(28, 2, 2100),  on_day(1, 3, 2100));
        send_dates(on_day(29, 2, 2100),  on_day(1, 3, 2100));
        send_dates(on_day(31, 4, 2020),  on_day(1, 1, 2020));
        send_dates(on_day(30, 4, 2020),  on_day(31, 1, 2021));
        send_dates(on_day(31, 7, 2023),  on_day(31, 11, 2023));
        send_dates(on_day(0, 5, 2020),   on_day(1, 1, 2020));
        send_dates(on_day(63, 15, 16383), on_day(1, 1, 2000));
        send_dates(on_day(0, 0, 0),      on_day(0, 0, 0));
        send_dates(on_day(1, 13, 2000),  on_day(1, 1, 2000));
        send_dates(on_day(15, 6, 1581),  on_day(1, 1, 2000));
        send_dates(on_day(15, 6, 2000),  on_day(15, 6, 10000));
        send_dates(on_day(15, 6, 2000),  on_day(31, 12, 16383));
        send_dates(on_day(15, 6, 2000),  on_day(0, 0, 1000));
        // day fault outranks year fault, first date outranks second
        send_dates(on_day(32, 1, 1000),  on_day(1, 1, 2000));
        send_dates(on_day(0, 1, 2000),   on_day(5, 0, 2000));
        send_dates(on_day(1, 1, 9999),   on_day(31, 12, 9998));
    endtask

    // year 0 counts as leap once the floor is down to 0
    task automatic test_year_zero_floor();
        send_dates(on_day(29, 2, 0), on_day(1, 1, 0));
        send_dates(on_day(1, 1, 0),  on_day(31, 12, 9999));
        send_dates(on_day(1, 3, 0),  on_day(29, 2, 400));
        send_dates(on_day(1, 1, 0),  on_day(1, 1, 16383));
    endtask

    task automatic test_random_dates(input int unsigned count, input bit allow_pause);
        t_cal_date a;
        t_cal_date b;
        repeat (count) begin
            a = gen_date($urandom_range(0, 7) != 0);
            b = gen_date($urandom_range(0, 7) != 0);
            send_dates(a, b);
            maybe_pause(allow_pause);
        end
    endtask

    task automatic test_earliest_sweep();
        set_earliest('0);
        test_year_zero_floor();
        test_random_dates(250, 1'b1);
        set_earliest(YEAR_W'(YEAR_CEILING));
        test_random_dates(80, 1'b1);
        // floor above the ceiling: no year can pass
        set_earliest('1);
        test_random_dates(50, 1'b1);
        set_earliest(YEAR_W'($urandom_range(YEAR_CEILING - 1, 1)));
        test_random_dates(250, 1'b1);
        set_earliest(EARLIEST_RESET);
        test_random_dates(150, 1'b0);
    endtask

    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_calendar_rules();
        test_random_dates(300, 1'b1);
        test_earliest_sweep();
        settle();
        if (error_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

`default_nettype wire

### files.f
+incdir+hdl
hdl/gdd_pkg.sv
hdl/gdd_date_unit.sv
hdl/gregorian_day_difference.sv
sim/testbench.sv
